[design/rbdm_pkg.sv]
// shared types and constants for the rounding boundary distance monitor
`timescale 1ns / 1ps

package rbdm_pkg;

  // value and field widths
  localparam int VAL_W   = 256;
  localparam int WIDTH_W = 9;     // holds a magnitude width of 0 to 256
  localparam int PREC_W  = 8;
  localparam int RMODE_W = 2;
  localparam int CNT_W   = 32;
  localparam int OUT_W   = 32;

  // fraction taken from the discarded bits
  localparam int FRAC_W = 32;
  localparam logic [FRAC_W-1:0] FRAC_MASK = {FRAC_W{1'b1}};
  localparam logic [FRAC_W-1:0] FRAC_HALF = {1'b1, {(FRAC_W-1){1'b0}}};

  // probe kinds and rounding modes
  localparam logic MODE_INTERNAL = 1'b0;
  localparam logic MODE_ENDPOINT = 1'b1;
  localparam logic [RMODE_W-1:0] RMODE_NEAREST_EVEN = 2'd0;

  // precision used by endpoint probes and the only one internal probes act on
  localparam logic [PREC_W-1:0] PROBE_PREC = 8'd64;

  localparam logic [CNT_W-1:0] CNT_FULL = {CNT_W{1'b1}};

  // one probe after fraction extraction
  typedef struct packed {
    logic                  mode;
    logic [PREC_W-1:0]     prec;
    logic [RMODE_W-1:0]    rmode;
    logic                  discarded;
    logic [FRAC_W-1:0]     frac;
  } probe_t;

  // one result item
  typedef struct packed {
    logic                  discarded;
    logic [FRAC_W-1:0]     frac;
    logic [FRAC_W-1:0]     item_gap;
    logic [FRAC_W-1:0]     nearest_int;
    logic [FRAC_W-1:0]     second_int;
    logic [FRAC_W-1:0]     nearest_fin;
    logic [CNT_W-1:0]      events;
  } result_t;

endpackage

[design/rounding_boundary_distance_monitor.sv]
// top level of the rounding boundary distance monitor
`timescale 1ns / 1ps

// Rounding boundary distance monitor. Each input transfer carries a 256-bit
// two's complement value, a probe kind, a precision and a rounding mode. The
// block takes the magnitude, finds its bit width, and, when the width exceeds
// the precision (the given one for internal probes, 64 for endpoint probes),
// takes the top 32 discarded bits, left-aligned, as a fraction. Internal
// probes at precision 64 under round-to-nearest-even with a nonzero fraction
// update the two smallest distances to one half and a saturating event
// counter; endpoint probes update the smallest distance to one half, zero or
// all ones. Every input transfer yields exactly one output transfer showing
// the item's own fraction and distance and the running figures after it.
// Throughput is one item per clock while the output is not stalled. The path
// is one input register, then negate, leading-one tree, shift and minima
// update in a single pass into the output register. The running minima reset
// to all ones and the counter to zero. Back pressure on the output stalls
// both registers; the input stays ready while the output register is empty
// or being drained.

module rounding_boundary_distance_monitor
  import rbdm_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,

  input  logic         in_tvalid,
  output logic         in_tready,
  // [7:0] precision, [9:8] rounding_mode, [73:10] value_w0, [137:74] value_w1,
  // [201:138] value_w2, [265:202] value_w3, [271:266] zero
  input  logic [271:0] in_tdata,
  // [0] mode
  input  logic         in_tuser,

  output logic         out_tvalid,
  input  logic         out_tready,
  // [0] bits_discarded, [32:1] item_fraction, [64:33] item_distance,
  // [96:65] nearest_internal, [128:97] second_internal,
  // [160:129] nearest_final, [192:161] internal_events, [199:193] zero
  output logic [199:0] out_tdata
);

  // input register
  logic               s1_valid_r;
  logic               s1_mode_r;
  logic [PREC_W-1:0]  s1_prec_r;
  logic [RMODE_W-1:0] s1_rmode_r;
  logic [VAL_W-1:0]   s1_value_r;

  // output register
  logic               out_valid_r;
  result_t            out_res_r;

  logic               s1_adv;
  logic               s1_fire;
  logic               in_fire;
  logic [PREC_W-1:0]  prec_used;
  logic               probe_disc;
  logic [FRAC_W-1:0]  probe_frac;
  probe_t             probe;
  result_t            res;

  // stage 1 moves on when the output register is empty or being drained
  assign s1_adv    = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && s1_adv;
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_mode_r  <= in_tuser;
      s1_prec_r  <= in_tdata[7:0];
      s1_rmode_r <= in_tdata[9:8];
      s1_value_r <= in_tdata[265:10];
    end
  end

  // endpoint probes always cut at the fixed precision
  assign prec_used = (s1_mode_r == MODE_ENDPOINT) ? PROBE_PREC : s1_prec_r;

  rbdm_extract u_extract (
    .value     (s1_value_r),
    .prec      (prec_used),
    .discarded (probe_disc),
    .frac      (probe_frac)
  );

  always_comb begin
    probe.mode      = s1_mode_r;
    probe.prec      = s1_prec_r;
    probe.rmode     = s1_rmode_r;
    probe.discarded = probe_disc;
    probe.frac      = probe_frac;
  end

  // running state commits only when the item leaves stage 1
  rbdm_track u_track (
    .clk    (clk),
    .rst_n  (rst_n),
    .upd_en (s1_fire),
    .probe  (probe),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0,
                       OUT_W'(out_res_r.events),
                       OUT_W'(out_res_r.nearest_fin),
                       OUT_W'(out_res_r.second_int),
                       OUT_W'(out_res_r.nearest_int),
                       OUT_W'(out_res_r.item_gap),
                       OUT_W'(out_res_r.frac),
                       out_res_r.discarded};

endmodule

[design/rbdm_msb.sv]
// leading-one tree: bit width of a 256-bit magnitude
`timescale 1ns / 1ps

module rbdm_msb
  import rbdm_pkg::*;
(
  input  logic [VAL_W-1:0]   mag,
  output logic [WIDTH_W-1:0] width
);

  function automatic logic [1:0] lead4(input logic [3:0] a);
    logic [1:0] r;
    r = 2'd0;
    if (a[1]) r = 2'd1;
    if (a[2]) r = 2'd2;
    if (a[3]) r = 2'd3;
    return r;
  endfunction

  logic       l0_any [64];
  logic [1:0] l0_pos [64];
  logic       l1_any [16];
  logic [3:0] l1_pos [16];
  logic       l2_any [4];
  logic [5:0] l2_pos [4];
  logic       l3_any;
  logic [7:0] l3_pos;

  // nibble level
  always_comb begin
    for (int g = 0; g < 64; g++) begin
      l0_any[g] = |mag[4*g +: 4];
      l0_pos[g] = lead4(mag[4*g +: 4]);
    end
  end

  // groups of four nibbles
  always_comb begin
    logic [3:0] a;
    logic [1:0] s;
    logic [1:0] p [4];
    for (int j = 0; j < 16; j++) begin
      for (int k = 0; k < 4; k++) begin
        a[k] = l0_any[4*j+k];
        p[k] = l0_pos[4*j+k];
      end
      s         = lead4(a);
      l1_any[j] = |a;
      l1_pos[j] = {s, p[s]};
    end
  end

  // groups of sixteen nibbles
  always_comb begin
    logic [3:0] a;
    logic [1:0] s;
    logic [3:0] p [4];
    for (int j = 0; j < 4; j++) begin
      for (int k = 0; k < 4; k++) begin
        a[k] = l1_any[4*j+k];
        p[k] = l1_pos[4*j+k];
      end
      s         = lead4(a);
      l2_any[j] = |a;
      l2_pos[j] = {s, p[s]};
    end
  end

  // whole word
  always_comb begin
    logic [3:0] a;
    logic [1:0] s;
    for (int k = 0; k < 4; k++) a[k] = l2_any[k];
    s      = lead4(a);
    l3_any = |a;
    l3_pos = {s, l2_pos[s]};
  end

  assign width = l3_any ? ({1'b0, l3_pos} + WIDTH_W'(1)) : '0;

endmodule

[design/rbdm_extract.sv]
// magnitude, width and left-aligned discarded fraction of one value
`timescale 1ns / 1ps

module rbdm_extract
  import rbdm_pkg::*;
(
  input  logic [VAL_W-1:0]  value,
  input  logic [PREC_W-1:0] prec,
  output logic              discarded,
  output logic [FRAC_W-1:0] frac
);

  logic [VAL_W-1:0]        mag;
  logic [WIDTH_W-1:0]      width;
  logic [WIDTH_W:0]        shift;
  logic [VAL_W+FRAC_W-1:0] ext;

  // the most negative value wraps to 2^255, read as unsigned
  assign mag = value[VAL_W-1] ? (~value + VAL_W'(1)) : value;

  rbdm_msb u_msb (
    .mag   (mag),
    .width (width)
  );

  // signed difference width - prec, one bit wider than the width
  assign shift     = {1'b0, width} - (WIDTH_W+1)'(prec);
  assign discarded = !shift[WIDTH_W] && (shift != '0);

  // bits below the kept part, top bit first; positions under bit 0 read as zero
  assign ext  = {mag, {FRAC_W{1'b0}}} >> shift[WIDTH_W-1:0];
  assign frac = discarded ? ext[FRAC_W-1:0] : '0;

endmodule

[design/rbdm_track.sv]
// running minima and event counter, updated once per probe
`timescale 1ns / 1ps

module rbdm_track
  import rbdm_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    upd_en,
  input  probe_t  probe,
  output result_t res
);

  logic [FRAC_W-1:0] best_int_r, best_int_nxt;
  logic [FRAC_W-1:0] second_int_r, second_int_nxt;
  logic [FRAC_W-1:0] best_fin_r, best_fin_nxt;
  logic [CNT_W-1:0]  events_r, events_nxt;

  logic [FRAC_W-1:0] hgap;
  logic [FRAC_W-1:0] egap;
  logic [FRAC_W-1:0] item_gap;
  logic              int_hit;

  function automatic logic [FRAC_W-1:0] half_gap(input logic [FRAC_W-1:0] f);
    return (f > FRAC_HALF) ? (f - FRAC_HALF) : (FRAC_HALF - f);
  endfunction

  assign hgap = half_gap(probe.frac);
  // distance to zero below one half, to all ones above
  assign egap = (probe.frac < FRAC_HALF) ? probe.frac : (FRAC_MASK - probe.frac);

  assign int_hit = (probe.mode == MODE_INTERNAL) && (probe.prec == PROBE_PREC) &&
                   (probe.rmode == RMODE_NEAREST_EVEN) && probe.discarded &&
                   (probe.frac != '0);

  always_comb begin
    best_int_nxt   = best_int_r;
    second_int_nxt = second_int_r;
    best_fin_nxt   = best_fin_r;
    events_nxt     = events_r;
    item_gap       = FRAC_MASK;
    if (probe.mode == MODE_INTERNAL) begin
      if (int_hit) begin
        item_gap = hgap;
        if (events_r != CNT_FULL) events_nxt = events_r + CNT_W'(1);
        if (hgap < best_int_r) begin
          second_int_nxt = best_int_r;
          best_int_nxt   = hgap;
        end else if (hgap < second_int_r) begin
          second_int_nxt = hgap;
        end
      end
    end else if (probe.discarded) begin
      item_gap = (hgap < egap) ? hgap : egap;
      if (item_gap < best_fin_r) best_fin_nxt = item_gap;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_int_r   <= FRAC_MASK;
      second_int_r <= FRAC_MASK;
      best_fin_r   <= FRAC_MASK;
      events_r     <= '0;
    end else if (upd_en) begin
      best_int_r   <= best_int_nxt;
      second_int_r <= second_int_nxt;
      best_fin_r   <= best_fin_nxt;
      events_r     <= events_nxt;
    end
  end

  always_comb begin
    res.discarded   = probe.discarded;
    res.frac        = probe.frac;
    res.item_gap    = item_gap;
    res.nearest_int = best_int_nxt;
    res.second_int  = second_int_nxt;
    res.nearest_fin = best_fin_nxt;
    res.events      = events_nxt;
  end

endmodule

[design/rbdm_checker.sv]
// port-level checks for the rounding boundary distance monitor, with bind
`timescale 1ns / 1ps

module rbdm_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [199:0] out_tdata
);

  localparam logic [31:0] HALF = 32'h8000_0000;
  localparam logic [31:0] NONE = 32'hFFFF_FFFF;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // input back pressure only comes from a stalled full output
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output back pressure");

  // the two internal minima stay ordered
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[96:65] <= out_tdata[128:97])
    else $error("internal minima out of order");

  // nothing discarded means an empty fraction and no distance
  a_no_discard: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[32:1] == '0 && out_tdata[64:33] == NONE)
    else $error("fraction or distance without discarded bits");

  // a distance, when given, never exceeds one half
  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[64:33] != NONE |-> out_tdata[64:33] <= HALF)
    else $error("distance beyond one half");

endmodule

bind rounding_boundary_distance_monitor rbdm_checker u_rbdm_checker (.*);
